/* hdl/sscfp_pkg.sv */
package sscfp_pkg;

  localparam int unsigned ByteW    = 8;
  localparam int unsigned CountW   = 32;
  localparam int unsigned StatusW  = 2;
  localparam int unsigned LenOutW  = 6;
  localparam int unsigned IdxOutW  = 5;
  localparam int unsigned RegIdxW  = 1;

  localparam logic [ByteW-1:0] HdrFirstRst  = 8'd83;
  localparam logic [ByteW-1:0] HdrSecondRst = 8'd89;

  localparam logic [RegIdxW-1:0] RegHdrFirst  = 1'b0;
  localparam logic [RegIdxW-1:0] RegHdrSecond = 1'b1;

  localparam logic [StatusW-1:0] StatusGood   = 2'd0;
  localparam logic [StatusW-1:0] StatusSumErr = 2'd1;
  localparam logic [StatusW-1:0] StatusLenErr = 2'd2;

  typedef struct packed {
    logic start;
    logic add_sum;
    logic ld_ctrl;
    logic ld_cmd;
    logic ld_lenh;
    logic ld_len;
    logic wr_byte;
    logic chk;
    logic len_err;
    logic emit_ld;
  } sscfp_cmd_t;

  typedef struct packed {
    logic hdr1_hit;
    logic hdr2_hit;
    logic len_over;
    logic len16_zero;
    logic exp_zero;
    logic data_done;
    logic sum_ok;
    logic out_free;
    logic emit_last;
  } sscfp_sts_t;

endpackage

/* hdl/sscfp_ram.sv */
module sscfp_ram #(
  parameter int unsigned WIDTH  = 8,
  parameter int unsigned DEPTH  = 32,
  parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* hdl/sscfp_ctrl.sv */
module sscfp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rx_valid_i,
  output logic               rx_stall_o,
  input  sscfp_pkg::sscfp_sts_t sts_i,
  output sscfp_pkg::sscfp_cmd_t cmd_o
);
  import sscfp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_HEAD,
    ST_CTRL,
    ST_CMD,
    ST_LENH,
    ST_LENL,
    ST_DATA,
    ST_SUM,
    ST_EMIT_RD,
    ST_EMIT_LD
  } state_e;

  state_e     state_q, state_d;
  sscfp_cmd_t cmd;
  logic       emitting;
  logic       acc;

  assign emitting   = (state_q == ST_EMIT_RD) || (state_q == ST_EMIT_LD);
  assign rx_stall_o = emitting ||
                      (((state_q == ST_LENL) || (state_q == ST_SUM)) && !sts_i.out_free);
  assign acc        = rx_valid_i && !rx_stall_o;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc && sts_i.hdr1_hit) begin
          cmd.start = 1'b1;
          state_d   = ST_HEAD;
        end
      end
      ST_HEAD: begin
        if (acc) begin
          if (sts_i.hdr2_hit) begin
            cmd.add_sum = 1'b1;
            state_d     = ST_CTRL;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_CTRL: begin
        if (acc) begin
          cmd.add_sum = 1'b1;
          cmd.ld_ctrl = 1'b1;
          state_d     = ST_CMD;
        end
      end
      ST_CMD: begin
        if (acc) begin
          cmd.add_sum = 1'b1;
          cmd.ld_cmd  = 1'b1;
          state_d     = ST_LENH;
        end
      end
      ST_LENH: begin
        if (acc) begin
          cmd.add_sum = 1'b1;
          cmd.ld_lenh = 1'b1;
          state_d     = ST_LENL;
        end
      end
      ST_LENL: begin
        if (acc) begin
          cmd.add_sum = 1'b1;
          cmd.ld_len  = 1'b1;
          if (sts_i.len_over) begin
            cmd.len_err = 1'b1;
            state_d     = ST_IDLE;
          end else if (sts_i.len16_zero) begin
            state_d = ST_SUM;
          end else begin
            state_d = ST_DATA;
          end
        end
      end
      ST_DATA: begin
        if (acc) begin
          cmd.add_sum = 1'b1;
          cmd.wr_byte = 1'b1;
          if (sts_i.data_done) begin
            state_d = ST_SUM;
          end
        end
      end
      ST_SUM: begin
        if (acc) begin
          cmd.chk = 1'b1;
          if (sts_i.sum_ok && !sts_i.exp_zero) begin
            state_d = ST_EMIT_RD;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_EMIT_RD: begin
        state_d = ST_EMIT_LD;
      end
      ST_EMIT_LD: begin
        if (sts_i.out_free) begin
          cmd.emit_ld = 1'b1;
          state_d     = sts_i.emit_last ? ST_IDLE : ST_EMIT_RD;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o = cmd;

endmodule

/* hdl/sscfp_dp.sv */
module sscfp_dp #(
  parameter int unsigned MAX_PAYLOAD = 32,
  parameter int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1,
  parameter int unsigned CW = $clog2(MAX_PAYLOAD + 1)
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  logic [sscfp_pkg::RegIdxW-1:0]           cfg_idx_i,
  input  logic [sscfp_pkg::ByteW-1:0]             cfg_data_i,
  input  logic [sscfp_pkg::ByteW-1:0]             rx_byte_i,
  input  sscfp_pkg::sscfp_cmd_t                   cmd_i,
  output sscfp_pkg::sscfp_sts_t                   sts_o,
  output logic                                    out_valid_o,
  input  logic                                    out_stall_i,
  output logic [sscfp_pkg::StatusW-1:0]           status_o,
  output logic [sscfp_pkg::ByteW-1:0]             ctrl_code_o,
  output logic [sscfp_pkg::ByteW-1:0]             cmd_code_o,
  output logic [sscfp_pkg::LenOutW-1:0]           payload_length_o,
  output logic [sscfp_pkg::IdxOutW-1:0]           byte_index_o,
  output logic [sscfp_pkg::ByteW-1:0]             payload_byte_o,
  output logic                                    last_o,
  output logic [sscfp_pkg::CountW-1:0]            total_frames_o,
  output logic [sscfp_pkg::CountW-1:0]            valid_frames_o,
  output logic [sscfp_pkg::CountW-1:0]            error_frames_o
);
  import sscfp_pkg::*;

  logic [ByteW-1:0]  hdr1_q, hdr2_q;
  logic [ByteW-1:0]  ctrl_q, cmd_q, lenh_q, sum_q, sum_d;
  logic [CW-1:0]     exp_len_q, pay_cnt_q, emit_idx_q;
  logic [CountW-1:0] tot_q, tot_d, val_q, val_d, err_q, err_d;
  logic [15:0]       len16;
  logic [CW:0]       pay_cnt_inc, emit_idx_inc;
  logic [ByteW-1:0]  ram_rdata;
  logic [CW+LenOutW-1:0] len_ext;
  logic [CW+IdxOutW-1:0] idx_ext;
  logic              out_take;
  logic              ld_single;
  logic [StatusW-1:0] single_status;

  logic              ov_q;
  logic [StatusW-1:0] st_q;
  logic [ByteW-1:0]  octrl_q, ocmd_q, obyte_q;
  logic [LenOutW-1:0] olen_q;
  logic [IdxOutW-1:0] oidx_q;
  logic              olast_q;
  logic [CountW-1:0] otot_q, oval_q, oerr_q;

  assign len16        = {lenh_q, rx_byte_i};
  assign pay_cnt_inc  = {1'b0, pay_cnt_q} + {{CW{1'b0}}, 1'b1};
  assign emit_idx_inc = {1'b0, emit_idx_q} + {{CW{1'b0}}, 1'b1};
  assign len_ext      = {{LenOutW{1'b0}}, exp_len_q};
  assign idx_ext      = {{IdxOutW{1'b0}}, emit_idx_q};

  assign sts_o.hdr1_hit   = (rx_byte_i == hdr1_q);
  assign sts_o.hdr2_hit   = (rx_byte_i == hdr2_q);
  assign sts_o.len_over   = (len16 > 16'(MAX_PAYLOAD));
  assign sts_o.len16_zero = (len16 == 16'd0);
  assign sts_o.exp_zero   = (exp_len_q == '0);
  assign sts_o.data_done  = (pay_cnt_inc >= {1'b0, exp_len_q});
  assign sts_o.sum_ok     = (rx_byte_i == sum_q);
  assign sts_o.out_free   = !ov_q || !out_stall_i;
  assign sts_o.emit_last  = (emit_idx_inc == {1'b0, exp_len_q});

  always_comb begin
    sum_d = sum_q;
    if (cmd_i.start) begin
      sum_d = rx_byte_i;
    end else if (cmd_i.add_sum) begin
      sum_d = sum_q + rx_byte_i;
    end
  end

  always_comb begin
    tot_d = tot_q;
    val_d = val_q;
    err_d = err_q;
    if (cmd_i.chk) begin
      tot_d = tot_q + 32'd1;
      if (sts_o.sum_ok) begin
        val_d = val_q + 32'd1;
      end else begin
        err_d = err_q + 32'd1;
      end
    end
    if (cmd_i.len_err) begin
      err_d = err_q + 32'd1;
    end
  end

  // single-beat results: length error, checksum error, empty good frame
  always_comb begin
    ld_single     = 1'b0;
    single_status = StatusGood;
    if (cmd_i.len_err) begin
      ld_single     = 1'b1;
      single_status = StatusLenErr;
    end else if (cmd_i.chk) begin
      if (!sts_o.sum_ok) begin
        ld_single     = 1'b1;
        single_status = StatusSumErr;
      end else if (sts_o.exp_zero) begin
        ld_single     = 1'b1;
        single_status = StatusGood;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr1_q     <= HdrFirstRst;
      hdr2_q     <= HdrSecondRst;
      ctrl_q     <= '0;
      cmd_q      <= '0;
      lenh_q     <= '0;
      sum_q      <= '0;
      exp_len_q  <= '0;
      pay_cnt_q  <= '0;
      emit_idx_q <= '0;
      tot_q      <= '0;
      val_q      <= '0;
      err_q      <= '0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          RegHdrFirst:  hdr1_q <= cfg_data_i;
          RegHdrSecond: hdr2_q <= cfg_data_i;
          default: ;
        endcase
      end
      sum_q <= sum_d;
      tot_q <= tot_d;
      val_q <= val_d;
      err_q <= err_d;
      if (cmd_i.start) begin
        lenh_q    <= '0;
        exp_len_q <= '0;
        pay_cnt_q <= '0;
      end
      if (cmd_i.ld_ctrl) begin
        ctrl_q <= rx_byte_i;
      end
      if (cmd_i.ld_cmd) begin
        cmd_q <= rx_byte_i;
      end
      if (cmd_i.ld_lenh) begin
        lenh_q <= rx_byte_i;
      end
      if (cmd_i.ld_len) begin
        pay_cnt_q <= '0;
        if (!sts_o.len_over) begin
          exp_len_q <= len16[CW-1:0];
        end
      end
      if (cmd_i.wr_byte) begin
        pay_cnt_q <= pay_cnt_inc[CW-1:0];
      end
      if (cmd_i.chk) begin
        emit_idx_q <= '0;
      end else if (cmd_i.emit_ld) begin
        emit_idx_q <= emit_idx_inc[CW-1:0];
      end
    end
  end

  sscfp_ram #(
    .WIDTH (ByteW),
    .DEPTH (MAX_PAYLOAD),
    .ADDR_W(AW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (cmd_i.wr_byte),
    .waddr_i(pay_cnt_q[AW-1:0]),
    .wdata_i(rx_byte_i),
    .raddr_i(emit_idx_q[AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // output beat register
  assign out_take = ov_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (ld_single || cmd_i.emit_ld) begin
      ov_q <= 1'b1;
    end else if (out_take) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_single) begin
      st_q    <= single_status;
      octrl_q <= (single_status == StatusGood) ? ctrl_q : '0;
      ocmd_q  <= (single_status == StatusGood) ? cmd_q : '0;
      olen_q  <= '0;
      oidx_q  <= '0;
      obyte_q <= '0;
      olast_q <= 1'b1;
      otot_q  <= tot_d;
      oval_q  <= val_d;
      oerr_q  <= err_d;
    end else if (cmd_i.emit_ld) begin
      st_q    <= StatusGood;
      octrl_q <= ctrl_q;
      ocmd_q  <= cmd_q;
      olen_q  <= len_ext[LenOutW-1:0];
      oidx_q  <= idx_ext[IdxOutW-1:0];
      obyte_q <= ram_rdata;
      olast_q <= sts_o.emit_last;
      otot_q  <= tot_d;
      oval_q  <= val_d;
      oerr_q  <= err_d;
    end
  end

  assign out_valid_o      = ov_q;
  assign status_o         = st_q;
  assign ctrl_code_o      = octrl_q;
  assign cmd_code_o       = ocmd_q;
  assign payload_length_o = olen_q;
  assign byte_index_o     = oidx_q;
  assign payload_byte_o   = obyte_q;
  assign last_o           = olast_q;
  assign total_frames_o   = otot_q;
  assign valid_frames_o   = oval_q;
  assign error_frames_o   = oerr_q;

endmodule

/* hdl/sum_checksum_frame_parser.sv */
// Frame parser for a byte stream carrying header, header, control, command,
// 16-bit big-endian length, payload and an 8-bit sum checksum. A received
// beat is accepted whenever rx is not stalled. The payload is buffered in a
// MAX_PAYLOAD-deep store; on a matching checksum the frame is played out as
// one beat per payload byte, each passing through the store's registered read
// port and the output register, and rx is stalled for the whole run. Error
// results and empty frames leave as a single beat loaded with the checksum or
// length byte; that byte waits only while the output register is full and not
// being drained. Header values are to be written by the user through the cfg
// port only while the parser is idle; the block itself does not enforce this.
module sum_checksum_frame_parser #(
  parameter int unsigned MAX_PAYLOAD = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [sscfp_pkg::RegIdxW-1:0]     cfg_idx_i,
  input  logic [sscfp_pkg::ByteW-1:0]       cfg_data_i,
  input  logic                              rx_valid_i,
  output logic                              rx_stall_o,
  input  logic [sscfp_pkg::ByteW-1:0]       rx_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [sscfp_pkg::StatusW-1:0]     status_o,
  output logic [sscfp_pkg::ByteW-1:0]       ctrl_code_o,
  output logic [sscfp_pkg::ByteW-1:0]       cmd_code_o,
  output logic [sscfp_pkg::LenOutW-1:0]     payload_length_o,
  output logic [sscfp_pkg::IdxOutW-1:0]     byte_index_o,
  output logic [sscfp_pkg::ByteW-1:0]       payload_byte_o,
  output logic                              last_o,
  output logic [sscfp_pkg::CountW-1:0]      total_frames_o,
  output logic [sscfp_pkg::CountW-1:0]      valid_frames_o,
  output logic [sscfp_pkg::CountW-1:0]      error_frames_o
);
  import sscfp_pkg::*;

  localparam int unsigned AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int unsigned CW = $clog2(MAX_PAYLOAD + 1);

  sscfp_cmd_t cmd;
  sscfp_sts_t sts;

  sscfp_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_valid_i(rx_valid_i),
    .rx_stall_o(rx_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  sscfp_dp #(
    .MAX_PAYLOAD(MAX_PAYLOAD),
    .AW         (AW),
    .CW         (CW)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_idx_i       (cfg_idx_i),
    .cfg_data_i      (cfg_data_i),
    .rx_byte_i       (rx_byte_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .ctrl_code_o     (ctrl_code_o),
    .cmd_code_o      (cmd_code_o),
    .payload_length_o(payload_length_o),
    .byte_index_o    (byte_index_o),
    .payload_byte_o  (payload_byte_o),
    .last_o          (last_o),
    .total_frames_o  (total_frames_o),
    .valid_frames_o  (valid_frames_o),
    .error_frames_o  (error_frames_o)
  );

endmodule

/* test/sum_checksum_frame_parser_test.sv */
module sum_checksum_frame_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  import sscfp_pkg::*;

  localparam int unsigned MaxPayload    = 32;
  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned DrainCycles   = 80;
  localparam int unsigned CfgPause      = 10;
  localparam int unsigned PhaseBeats    = 95;

  typedef enum logic [2:0] {Hunt, Hdr2, CtrlB, CmdB, LenHi, LenLo, DataB, SumB} parse_e;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [ByteW-1:0]   ctrl;
    logic [ByteW-1:0]   cmd;
    logic [LenOutW-1:0] len;
    logic [IdxOutW-1:0] idx;
    logic [ByteW-1:0]   data;
    logic               last;
    logic [CountW-1:0]  total;
    logic [CountW-1:0]  good;
    logic [CountW-1:0]  bad;
  } frame_item_t;

  typedef struct packed {
    logic [ByteW-1:0] rx;
    logic             typed;
    frame_item_t      want;
  } script_row_t;

  localparam frame_item_t NoItem = '0;

  // noise with a broken second header, an over-limit length, an empty good frame
  // with ctrl/cmd at 0xff, and a one-byte frame with a bad checksum
  localparam script_row_t Script [26] = '{
    {8'h53, 1'b0, NoItem}, {8'h53, 1'b0, NoItem}, {8'h59, 1'b0, NoItem},
    {8'h00, 1'b0, NoItem}, {8'h00, 1'b0, NoItem},
    {8'h53, 1'b0, NoItem}, {8'h59, 1'b0, NoItem}, {8'h00, 1'b0, NoItem},
    {8'h00, 1'b0, NoItem}, {8'h00, 1'b0, NoItem},
    {8'h21, 1'b1, StatusLenErr, 8'h00, 8'h00, 6'd0, 5'd0, 8'h00, 1'b1,
     32'd0, 32'd0, 32'd1},
    {8'h53, 1'b0, NoItem}, {8'h59, 1'b0, NoItem}, {8'hff, 1'b0, NoItem},
    {8'hff, 1'b0, NoItem}, {8'h00, 1'b0, NoItem}, {8'h00, 1'b0, NoItem},
    {8'haa, 1'b1, StatusGood, 8'hff, 8'hff, 6'd0, 5'd0, 8'h00, 1'b1,
     32'd1, 32'd1, 32'd1},
    {8'h53, 1'b0, NoItem}, {8'h59, 1'b0, NoItem}, {8'h12, 1'b0, NoItem},
    {8'h34, 1'b0, NoItem}, {8'h00, 1'b0, NoItem}, {8'h01, 1'b0, NoItem},
    {8'h7e, 1'b0, NoItem},
    {8'h00, 1'b1, StatusSumErr, 8'h00, 8'h00, 6'd0, 5'd0, 8'h00, 1'b1,
     32'd2, 32'd1, 32'd2}
  };

  localparam logic [ByteW-1:0] PhaseFirst [3]  = '{8'h00, 8'hff, 8'ha5};
  localparam logic [ByteW-1:0] PhaseSecond [3] = '{8'hff, 8'h00, 8'ha5};
  localparam int PhaseSendIdle [3] = '{13, 48, 0};
  localparam int PhaseRecvIdle [3] = '{48, 13, 0};

  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                cfg_we_i   = 1'b0;
  logic [RegIdxW-1:0]  cfg_idx_i  = RegHdrFirst;
  logic [ByteW-1:0]    cfg_data_i = '0;
  logic                rx_valid_i = 1'b0;
  logic                rx_stall_o;
  logic [ByteW-1:0]    rx_byte_i  = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [StatusW-1:0]  status_o;
  logic [ByteW-1:0]    ctrl_code_o;
  logic [ByteW-1:0]    cmd_code_o;
  logic [LenOutW-1:0]  payload_length_o;
  logic [IdxOutW-1:0]  byte_index_o;
  logic [ByteW-1:0]    payload_byte_o;
  logic                last_o;
  logic [CountW-1:0]   total_frames_o;
  logic [CountW-1:0]   valid_frames_o;
  logic [CountW-1:0]   error_frames_o;

  sum_checksum_frame_parser #(.MAX_PAYLOAD(MaxPayload)) DUT (.*);

  always #10 clk_i = ~clk_i;

  // parser mirror
  logic [ByteW-1:0]  hdr_first, hdr_second, frame_ctrl, frame_cmd, len_hi, run_sum;
  parse_e            phase;
  logic [ByteW-1:0]  payload_mem [MaxPayload];
  int unsigned       want_len, got_len;
  logic [CountW-1:0] total_cnt, good_cnt, bad_cnt;

  frame_item_t made_items [$];
  frame_item_t due_items [$];
  int          send_idle_pct = 13;
  int          recv_idle_pct = 48;
  int          fail_cnt = 0;
  int unsigned quiet_cycles = 0;
  int unsigned beats_sent = 0;

  function automatic frame_item_t make_item(input logic [StatusW-1:0] st,
                                            input logic [ByteW-1:0] c,
                                            input logic [ByteW-1:0] m,
                                            input int unsigned len,
                                            input int unsigned idx,
                                            input logic [ByteW-1:0] d,
                                            input logic lst);
    frame_item_t x;
    x.status = st;
    x.ctrl   = c;
    x.cmd    = m;
    x.len    = LenOutW'(len);
    x.idx    = IdxOutW'(idx);
    x.data   = d;
    x.last   = lst;
    x.total  = total_cnt;
    x.good   = good_cnt;
    x.bad    = bad_cnt;
    return x;
  endfunction

  function automatic string describe(input frame_item_t x);
    return $sformatf({"status=%0d ctrl=%02h cmd=%02h len=%0d idx=%0d byte=%02h last=%0b",
                      " total=%0d valid=%0d error=%0d"},
                     x.status, x.ctrl, x.cmd, x.len, x.idx, x.data, x.last,
                     x.total, x.good, x.bad);
  endfunction

  task automatic reset_model();
    hdr_first  = HdrFirstRst;
    hdr_second = HdrSecondRst;
    phase      = Hunt;
    frame_ctrl = '0;
    frame_cmd  = '0;
    len_hi     = '0;
    run_sum    = '0;
    want_len   = 0;
    got_len    = 0;
    total_cnt  = '0;
    good_cnt   = '0;
    bad_cnt    = '0;
    foreach (payload_mem[k]) payload_mem[k] = '0;
  endtask

  task automatic mirror_rx_beat(input logic [ByteW-1:0] b);
    int unsigned len16;
    made_items.delete();
    case (phase)
      Hunt: if (b == hdr_first) begin
        run_sum  = b;
        len_hi   = '0;
        want_len = 0;
        got_len  = 0;
        phase    = Hdr2;
      end
      Hdr2: if (b == hdr_second) begin
        run_sum += b;
        phase = CtrlB;
      end else begin
        phase = Hunt;
      end
      CtrlB: begin
        frame_ctrl = b;
        run_sum += b;
        phase = CmdB;
      end
      CmdB: begin
        frame_cmd = b;
        run_sum += b;
        phase = LenHi;
      end
      LenHi: begin
        len_hi = b;
        run_sum += b;
        phase = LenLo;
      end
      LenLo: begin
        run_sum += b;
        len16 = {len_hi, b};
        got_len = 0;
        if (len16 > MaxPayload) begin
          bad_cnt++;
          made_items.push_back(make_item(StatusLenErr, '0, '0, 0, 0, '0, 1'b1));
          phase = Hunt;
        end else begin
          want_len = len16;
          phase = (len16 == 0) ? SumB : DataB;
        end
      end
      DataB: begin
        run_sum += b;
        if (got_len < MaxPayload) payload_mem[got_len] = b;
        got_len++;
        if (got_len >= want_len) phase = SumB;
      end
      default: begin
        total_cnt++;
        if (b == run_sum) begin
          good_cnt++;
          if (want_len == 0) begin
            made_items.push_back(make_item(StatusGood, frame_ctrl, frame_cmd, 0, 0, '0, 1'b1));
          end else begin
            for (int unsigned i = 0; i < want_len && i < MaxPayload; i++) begin
              made_items.push_back(make_item(StatusGood, frame_ctrl, frame_cmd, want_len, i,
                                             payload_mem[i], i + 1 == want_len));
            end
          end
        end else begin
          bad_cnt++;
          made_items.push_back(make_item(StatusSumErr, '0, '0, 0, 0, '0, 1'b1));
        end
        phase = Hunt;
      end
    endcase
  endtask

  task automatic send_raw(input logic [ByteW-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (rx_stall_o !== 1'b0);
    beats_sent++;
    mirror_rx_beat(b);
  endtask

  task automatic feed(input logic [ByteW-1:0] b);
    send_raw(b);
    foreach (made_items[k]) due_items.push_back(made_items[k]);
  endtask

  task automatic back_to_hunt();
    while (phase != Hunt) feed(8'($urandom));
  endtask

  task automatic send_frame(input int unsigned len16, input bit sum_ok);
    logic [ByteW-1:0] s, b;
    s = hdr_first + hdr_second;
    feed(hdr_first);
    feed(hdr_second);
    repeat (2) begin
      b = 8'($urandom);
      s += b;
      feed(b);
    end
    b = 8'(len16 >> 8);
    s += b;
    feed(b);
    b = 8'(len16);
    s += b;
    feed(b);
    if (len16 <= MaxPayload) begin
      repeat (len16) begin
        b = 8'($urandom);
        s += b;
        feed(b);
      end
      b = sum_ok ? s : s + 8'($urandom_range(255, 1));
      feed(b);
    end
  endtask

  task automatic run_traffic(input int unsigned budget);
    int unsigned stop_at, pick, len16;
    stop_at = beats_sent + budget;
    while (beats_sent < stop_at) begin
      back_to_hunt();
      pick = $urandom_range(99);
      if (pick < 75) begin
        pick = $urandom_range(99);
        if (pick < 45) len16 = $urandom_range(4);
        else if (pick < 65) len16 = $urandom_range(31, 5);
        else if (pick < 80) len16 = MaxPayload;
        else if (pick < 88) len16 = MaxPayload + 1;
        else len16 = $urandom_range(65535, MaxPayload + 2);
        send_frame(len16, $urandom_range(99) < 80);
      end else if (pick < 87) begin
        repeat ($urandom_range(3, 1)) feed(8'($urandom));
      end else begin
        feed(hdr_first);
        feed(hdr_second ^ 8'($urandom_range(255, 1)));
      end
    end
    back_to_hunt();
  endtask

  task automatic settle(input int unsigned extra);
    while (due_items.size() != 0) @(posedge clk_i);
    repeat (extra) @(posedge clk_i);
  endtask

  task automatic set_headers(input logic [ByteW-1:0] first, input logic [ByteW-1:0] second);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= RegHdrFirst;
    cfg_data_i <= first;
    @(posedge clk_i);
    cfg_idx_i  <= RegHdrSecond;
    cfg_data_i <= second;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    hdr_first  = first;
    hdr_second = second;
  endtask

  initial begin
    reset_model();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    foreach (Script[r]) begin
      send_raw(Script[r].rx);
      if (Script[r].typed) begin
        due_items.push_back(Script[r].want);
      end else begin
        foreach (made_items[k]) due_items.push_back(made_items[k]);
      end
    end
    for (int p = 0; p < 3; p++) begin
      rx_valid_i <= 1'b0;
      settle(CfgPause);
      set_headers(PhaseFirst[p], PhaseSecond[p]);
      send_idle_pct = PhaseSendIdle[p];
      recv_idle_pct = PhaseRecvIdle[p];
      run_traffic(PhaseBeats);
    end
    rx_valid_i <= 1'b0;
    settle(DrainCycles);
    if (fail_cnt == 0 && due_items.size() == 0) begin
      $display("sum_checksum_frame_parser test passed");
    end else begin
      $display("sum_checksum_frame_parser test failed");
    end
    $finish;
  end

  // result check and watchdog
  always @(posedge clk_i) begin
    frame_item_t seen;
    out_stall_i <= $urandom_range(99) < recv_idle_pct;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        seen = {status_o, ctrl_code_o, cmd_code_o, payload_length_o, byte_index_o,
                payload_byte_o, last_o, total_frames_o, valid_frames_o, error_frames_o};
        if (due_items.size() == 0) begin
          fail_cnt++;
          $display("%0t: unexpected beat %s", $time, describe(seen));
        end else begin
          if (seen !== due_items[0]) begin
            fail_cnt++;
            $display("%0t: beat mismatch\n  expected %s\n  actual   %s", $time,
                     describe(due_items[0]), describe(seen));
          end
          void'(due_items.pop_front());
        end
      end
      if ((out_valid_o && !out_stall_i) || (rx_valid_i && !rx_stall_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WatchdogLimit) begin
          $display("sum_checksum_frame_parser test failed");
          $finish;
        end
      end
    end
  end

endmodule

/* files.f */
hdl/sscfp_pkg.sv
hdl/sscfp_ram.sv
hdl/sscfp_ctrl.sv
hdl/sscfp_dp.sv
hdl/sum_checksum_frame_parser.sv
test/sum_checksum_frame_parser_test.sv
